@@ rtl/multi_scale_rms_peak_tracker_top_defines.svh @@
// Assertion macros shared by the RMS and peak level meter RTL.
`ifndef MULTI_SCALE_RMS_PEAK_TRACKER_TOP_DEFINES_SVH
`define MULTI_SCALE_RMS_PEAK_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSRPT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MSRPT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSRPT_ASSERT(label, clk, rstn, prop, msg)
`define MSRPT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/msrpt_pkg.sv @@
// Package with the shared types, constants and codes of the level meter.
`timescale 1ns / 1ps
`default_nettype none
package msrpt_pkg;
    localparam int BLOCK_MAX = 4096;
    localparam int CNT_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W = 32 + CNT_W - 2;
    localparam int MEAN_W = 31;
    localparam logic [16:0] ONE_Q15 = 17'd32768;
    localparam logic [15:0] DECAY_Q16 = 16'd65529;
    localparam logic [15:0] W_FAST = 16'd13107;
    localparam logic [15:0] W_MEDIUM = 16'd32768;
    localparam logic [15:0] W_SLOW = 16'd19661;
    localparam logic [15:0] RATIO_ONE = 16'd256;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_DECAY  = 2'd1,
        MODE_SOFT   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_FAST   = 3'd0,
        REG_MEDIUM = 3'd1,
        REG_SLOW   = 3'd2,
        REG_PEAK   = 3'd3,
        REG_NONRES = 3'd4,
        REG_FLOOR  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_CLOSE = 2'd0,
        CMD_DECAY = 2'd1,
        CMD_SOFT  = 2'd2
    } cmd_kind_t;

    // One queued command from the front part to the back part.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic [15:0]       peak;
    } cmd_t;

    typedef struct packed {
        logic [15:0] fast_c;
        logic [15:0] medium_c;
        logic [15:0] slow_c;
        logic [15:0] peak_c;
        logic        non_resetting;
        logic [15:0] floor_q;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_SQRT, ST_BLEND, ST_PEAK, ST_DECAY, ST_FLOOR,
        ST_LOUD, ST_RATIO_A, ST_RATIO_B, ST_OUT
    } bstate_t;
endpackage
`default_nettype wire

@@ rtl/multi_scale_rms_peak_tracker_top.sv @@
// Top level of the multi-time-constant RMS and peak level meter.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_mode, s_sample, s_last
//  m_       out        m_valid / m_ready    eight Q1.15 / Q8.8 level fields
//  cfg      in         cfg_we               cfg_index, cfg_data
//
// Samples are taken one per cycle while the command queue has room; the front accumulates while the back works.
// A block close runs the back part through a serial divide of the square sum
// (one bit per cycle), a square root (two bits per cycle), a blend of the three
// levels, a step each for peak, floor and loudness, two serial ratio divides
// and an output step. Decay and soft reset skip the divide, root and ratios.
// A two-entry command queue lets the front keep accepting samples while the
// back is busy; it stalls only when the queue fills.
// Reset is synchronous on aresetn low and clears all level and block state.
`timescale 1ns / 1ps
`default_nettype none
module multi_scale_rms_peak_tracker_top (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire [2:0]         cfg_index,
    input  wire [15:0]        cfg_data,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire [1:0]         s_mode,
    input  wire signed [15:0] s_sample,
    input  wire               s_last,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [15:0]       m_crest_factor,
    output logic [15:0]       m_dynamic_range,
    output logic [15:0]       m_loudness,
    output logic [15:0]       m_peak_out,
    output logic [15:0]       m_fast_level,
    output logic [15:0]       m_medium_level,
    output logic [15:0]       m_slow_level,
    output logic [15:0]       m_max_peak_out
);
    import msrpt_pkg::*;

    cfg_t cfg_reg;
    cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    // Configuration registers, written by index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_c <= 16'd65;
            cfg_reg.medium_c <= 16'd13;
            cfg_reg.slow_c <= 16'd3;
            cfg_reg.peak_c <= 16'd7;
            cfg_reg.non_resetting <= 1'b0;
            cfg_reg.floor_q <= 16'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FAST:   cfg_reg.fast_c <= cfg_data;
                REG_MEDIUM: cfg_reg.medium_c <= cfg_data;
                REG_SLOW:   cfg_reg.slow_c <= cfg_data;
                REG_PEAK:   cfg_reg.peak_c <= cfg_data;
                REG_NONRES: cfg_reg.non_resetting <= cfg_data[0];
                REG_FLOOR:  cfg_reg.floor_q <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    msrpt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_mode(s_mode), .in_sample(s_sample), .in_last(s_last),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    msrpt_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    msrpt_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_crest_factor(m_crest_factor), .m_dynamic_range(m_dynamic_range),
        .m_loudness(m_loudness), .m_peak_out(m_peak_out),
        .m_fast_level(m_fast_level), .m_medium_level(m_medium_level),
        .m_slow_level(m_slow_level), .m_max_peak_out(m_max_peak_out)
    );
endmodule
`default_nettype wire

@@ rtl/msrpt_front.sv @@
// Front part: accumulates squares and peak of a block and issues commands.
`timescale 1ns / 1ps
`default_nettype none
module msrpt_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire [1:0]            in_mode,
    input  wire signed [15:0]    in_sample,
    input  wire                  in_last,
    output logic                 cmd_valid,
    input  wire                  cmd_ready,
    output msrpt_pkg::cmd_t      cmd
);
    import msrpt_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [15:0]      max_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             cv_reg;
    cmd_t             cmd_reg;

    logic [15:0]      mag;
    logic [31:0]      sq;
    logic [SUM_W-1:0] sum_next;
    logic [15:0]      max_next;
    logic [CNT_W-1:0] cnt_next;
    logic             fire;
    logic             close_blk;
    logic             issue;
    mode_t            mode;

    assign mode     = mode_t'(in_mode);
    assign in_ready = !cv_reg || cmd_ready;
    assign fire     = in_valid && in_ready;
    assign mag      = in_sample[15] ? 16'(-in_sample) : in_sample;
    assign sq       = mag * mag;
    assign sum_next = sum_reg + SUM_W'(sq);
    assign max_next = (mag > max_reg) ? mag : max_reg;
    assign cnt_next = cnt_reg + 1'b1;

    // A block closes on its flagged last sample or when it reaches the length limit.
    assign close_blk = in_last || cnt_next >= CNT_W'(BLOCK_MAX);
    assign issue = fire && (mode == MODE_DECAY || mode == MODE_SOFT ||
                            (mode == MODE_SAMPLE && close_blk));

    assign cmd_valid = cv_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            max_reg <= '0;
            cnt_reg <= '0;
            cv_reg  <= 1'b0;
        end else begin
            if (issue) begin
                cv_reg <= 1'b1;
            end else if (cmd_ready) begin
                cv_reg <= 1'b0;
            end
            if (fire) begin
                unique case (mode)
                    MODE_SAMPLE: begin
                        if (close_blk) begin
                            cmd_reg.kind  <= CMD_CLOSE;
                            cmd_reg.sum   <= sum_next;
                            cmd_reg.count <= cnt_next;
                            cmd_reg.peak  <= max_next;
                            sum_reg       <= '0;
                            max_reg       <= '0;
                            cnt_reg       <= '0;
                        end else begin
                            sum_reg <= sum_next;
                            max_reg <= max_next;
                            cnt_reg <= cnt_next;
                        end
                    end
                    MODE_DECAY: begin
                        cmd_reg.kind <= CMD_DECAY;
                    end
                    MODE_SOFT: begin
                        cmd_reg.kind <= CMD_SOFT;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/msrpt_fifo.sv @@
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_scale_rms_peak_tracker_top_defines.svh"
module msrpt_fifo (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_valid,
    output logic             wr_ready,
    input  msrpt_pkg::cmd_t  wr_data,
    output logic             rd_valid,
    input  wire              rd_ready,
    output msrpt_pkg::cmd_t  rd_data
);
    import msrpt_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    `MSRPT_ASSERT(a_fifo_cnt, aclk, aresetn, cnt_reg != 2'd3, "queue count out of range")
    `MSRPT_ASSERT(a_fifo_full, aclk, aresetn, (cnt_reg == 2'd2 && !rd) |=> cnt_reg == 2'd2,
        "queue lost an entry")
    `MSRPT_ASSERT(a_fifo_ptr, aclk, aresetn, (cnt_reg == 2'd0) |-> (wp_reg == rp_reg),
        "queue pointers disagree when empty")
endmodule
`default_nettype wire

@@ rtl/msrpt_back.sv @@
// Back part: block RMS by serial divide and root, level updates, result.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_scale_rms_peak_tracker_top_defines.svh"
module msrpt_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  msrpt_pkg::cfg_t  cfg,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    input  msrpt_pkg::cmd_t  cmd,
    output logic             m_valid,
    input  wire              m_ready,
    output logic [15:0]      m_crest_factor,
    output logic [15:0]      m_dynamic_range,
    output logic [15:0]      m_loudness,
    output logic [15:0]      m_peak_out,
    output logic [15:0]      m_fast_level,
    output logic [15:0]      m_medium_level,
    output logic [15:0]      m_slow_level,
    output logic [15:0]      m_max_peak_out
);
    import msrpt_pkg::*;

    bstate_t state_reg, state_next;
    logic [5:0]        step_reg, step_next;
    logic [SUM_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [MEAN_W+1:0] x_reg, x_next;
    logic [MEAN_W+1:0] root_reg, root_next;
    logic [15:0]       bpk_reg, bpk_next;
    logic [16:0]       rms_reg, rms_next;
    logic [15:0]       fast_reg, fast_next, med_reg, med_next, slow_reg, slow_next;
    logic [15:0]       pk_reg, pk_next, hist_reg, hist_next;
    logic [1:0]        lane_reg, lane_next;
    logic [25:0]       rn_reg, rn_next;
    logic [16:0]       rd_reg, rd_next;
    logic [17:0]       rr_reg, rr_next;
    logic [15:0]       crest_reg, crest_next, dyn_reg, dyn_next, loud_reg, loud_next;
    logic              ov_reg, ov_next;
    logic              fire;
    logic              load_out;

    // Shared one-pole blend unit: one multiply pair per cycle.
    logic [15:0] b_old, b_tgt, b_c;
    logic [16:0] b_keep;
    logic [32:0] b_p0;
    logic [31:0] b_p1;
    logic [33:0] b_sum;
    logic [15:0] b_res;
    logic [16:0] flr;
    logic [CNT_W:0]    rem_sh;
    logic [MEAN_W+1:0] trial;
    logic [18:0] rr_sh;
    logic [31:0] l_f, l_m, l_s;
    logic [33:0] loud_sum;
    logic [31:0] dec_prod;

    assign b_keep = 17'h10000 - {1'b0, b_c};
    assign b_p0 = b_old * b_keep;
    assign b_p1 = b_tgt * b_c;
    assign b_sum = {1'b0, b_p0} + {2'b0, b_p1} + 34'd32768;
    assign b_res = b_sum[31:16];
    assign flr = (cfg.floor_q > 16'(ONE_Q15)) ? ONE_Q15 : {1'b0, cfg.floor_q};
    assign rem_sh = {rem_reg[CNT_W-1:0], num_reg[SUM_W-1]};
    assign trial = {root_reg[MEAN_W-1:0], 2'b01};
    assign rr_sh = {rr_reg, rn_reg[25]};
    assign l_f = fast_reg * W_FAST;
    assign l_m = med_reg * W_MEDIUM;
    assign l_s = slow_reg * W_SLOW;
    assign loud_sum = {2'b0, l_f} + {2'b0, l_m} + {2'b0, l_s} + 34'd32768;

    always_comb begin
        unique case (lane_reg)
            2'd0: begin b_old = fast_reg; b_c = cfg.fast_c; end
            2'd1: begin b_old = med_reg;  b_c = cfg.medium_c; end
            default: begin b_old = slow_reg; b_c = cfg.slow_c; end
        endcase
        b_tgt = rms_reg[15:0] | {rms_reg[16], 15'd0};
        if (state_reg == ST_PEAK) begin
            b_old = pk_reg;
            b_c   = cfg.peak_c;
            b_tgt = bpk_reg;
        end
        unique case (lane_reg)
            2'd0: dec_prod = fast_reg * DECAY_Q16;
            2'd1: dec_prod = med_reg * DECAY_Q16;
            2'd2: dec_prod = slow_reg * DECAY_Q16;
            default: dec_prod = hist_reg * DECAY_Q16;
        endcase
    end

    assign cmd_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign fire = cmd_valid && cmd_ready;
    // The output register takes a new result once the old one has left.
    assign load_out = (state_reg == ST_OUT) && (!ov_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg;
        x_next = x_reg; root_next = root_reg; bpk_next = bpk_reg; rms_next = rms_reg;
        fast_next = fast_reg; med_next = med_reg; slow_next = slow_reg;
        pk_next = pk_reg; hist_next = hist_reg; lane_next = lane_reg;
        rn_next = rn_reg; rd_next = rd_reg; rr_next = rr_reg;
        crest_next = crest_reg; dyn_next = dyn_reg; loud_next = loud_reg;
        ov_next = ov_reg;
        if (ov_reg && m_ready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    unique case (cmd.kind)
                        CMD_CLOSE: begin
                            num_next = cmd.sum;
                            den_next = cmd.count;
                            rem_next = '0;
                            bpk_next = cmd.peak;
                            step_next = 6'(SUM_W - 1);
                            state_next = ST_DIV;
                        end
                        CMD_DECAY: begin
                            lane_next = 2'd0;
                            state_next = ST_DECAY;
                        end
                        default: begin
                            if (!cfg.non_resetting) begin
                                fast_next = '0; med_next = '0; slow_next = '0;
                                pk_next = '0; hist_next = '0;
                            end else begin
                                state_next = ST_FLOOR;
                            end
                        end
                    endcase
                end
            end
            // Restoring divide: one quotient bit per cycle, quotient shifts into num.
            ST_DIV: begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    num_next = {num_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    num_next = {num_reg[SUM_W-2:0], 1'b0};
                end
                if (step_reg == '0) begin
                    x_next = '0;
                    root_next = '0;
                    step_next = 6'(MEAN_W/2);
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            // Digit-by-digit square root, two radicand bits per cycle.
            ST_SQRT: begin
                x_next = {x_reg[MEAN_W-1:0],
                          num_reg[2*step_reg[3:0]+1], num_reg[2*step_reg[3:0]]};
                if (x_next >= trial) begin
                    x_next = x_next - trial;
                    root_next = {root_reg[MEAN_W:0], 1'b1};
                end else begin
                    root_next = {root_reg[MEAN_W:0], 1'b0};
                end
                if (step_reg == '0) begin
                    lane_next = 2'd0;
                    state_next = ST_BLEND;
                end else begin
                    step_next = step_reg - 1'b1;
                end
                rms_next = (root_next > 33'(ONE_Q15)) ? ONE_Q15 : root_next[16:0];
            end
            ST_BLEND: begin
                unique case (lane_reg)
                    2'd0: fast_next = b_res;
                    2'd1: med_next = b_res;
                    default: slow_next = b_res;
                endcase
                if (lane_reg == 2'd2) state_next = ST_PEAK;
                else lane_next = lane_reg + 1'b1;
            end
            ST_PEAK: begin
                if (bpk_reg > pk_reg) begin
                    pk_next = bpk_reg;
                    if (bpk_reg > hist_reg) hist_next = bpk_reg;
                end else begin
                    pk_next = b_res;
                end
                state_next = ST_FLOOR;
            end
            ST_DECAY: begin
                unique case (lane_reg)
                    2'd0: fast_next = dec_prod[31:16];
                    2'd1: med_next = dec_prod[31:16];
                    2'd2: slow_next = dec_prod[31:16];
                    default: hist_next = dec_prod[31:16];
                endcase
                if (lane_reg == 2'd3) state_next = ST_FLOOR;
                else lane_next = lane_reg + 1'b1;
            end
            ST_FLOOR: begin
                if (cfg.non_resetting) begin
                    if ({1'b0, fast_reg} < flr) fast_next = flr[15:0] | {flr[16], 15'd0};
                    if ({1'b0, med_reg} < flr) med_next = flr[15:0] | {flr[16], 15'd0};
                    if ({1'b0, slow_reg} < flr) slow_next = flr[15:0] | {flr[16], 15'd0};
                end
                state_next = (step_reg == 6'h3f) ? ST_LOUD : ST_IDLE;
            end
            ST_LOUD: begin
                loud_next = loud_sum[31:16];
                rn_next = {pk_reg, 8'd0, 2'd0};
                rd_next = {1'b0, fast_reg};
                rr_next = '0;
                step_next = 6'd23;
                state_next = ST_RATIO_A;
            end
            ST_RATIO_A, ST_RATIO_B: begin
                rn_next = {rn_reg[24:0], 1'b0};
                if (rr_sh >= {2'b0, rd_reg}) begin
                    rr_next = 18'(rr_sh - {2'b0, rd_reg});
                    rn_next[0] = 1'b1;
                end else begin
                    rr_next = rr_sh[17:0];
                end
                if (step_reg == '0) begin
                    if (state_reg == ST_RATIO_A) begin
                        crest_next = (rd_reg == '0) ? RATIO_ONE
                                   : (|rn_next[25:16]) ? 16'hffff : rn_next[15:0];
                        rn_next = {hist_reg, 8'd0, 2'd0};
                        rd_next = {1'b0, slow_reg};
                        rr_next = '0;
                        step_next = 6'd23;
                        state_next = ST_RATIO_B;
                    end else begin
                        dyn_next = (rd_reg == '0) ? RATIO_ONE
                                 : (|rn_next[25:16]) ? 16'hffff : rn_next[15:0];
                        state_next = ST_OUT;
                    end
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_OUT: begin
                if (!ov_next) begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // The close path marks itself so the floor step knows to report.
        if (state_reg == ST_PEAK) step_next = 6'h3f;
        if (state_reg == ST_IDLE && fire && cmd.kind != CMD_CLOSE) step_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            fast_reg <= '0; med_reg <= '0; slow_reg <= '0;
            pk_reg <= '0; hist_reg <= '0;
            step_reg <= '0;
            lane_reg <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            fast_reg <= fast_next; med_reg <= med_next; slow_reg <= slow_next;
            pk_reg <= pk_next; hist_reg <= hist_next;
            step_reg <= step_next;
            lane_reg <= lane_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next; den_reg <= den_next; rem_reg <= rem_next;
        x_reg <= x_next; root_reg <= root_next; bpk_reg <= bpk_next;
        rms_reg <= rms_next; rn_reg <= rn_next; rd_reg <= rd_next; rr_reg <= rr_next;
        crest_reg <= crest_next; dyn_reg <= dyn_next; loud_reg <= loud_next;
        if (load_out) begin
            m_peak_out <= pk_reg;
            m_fast_level <= fast_reg;
            m_medium_level <= med_reg;
            m_slow_level <= slow_reg;
            m_max_peak_out <= hist_reg;
            m_crest_factor <= crest_reg;
            m_dynamic_range <= dyn_reg;
            m_loudness <= loud_reg;
        end
    end

    assign m_valid = ov_reg;

    `MSRPT_ASSERT(a_hold, aclk, aresetn, (ov_reg && !m_ready) |=> ov_reg,
        "result dropped while stalled")
    `MSRPT_ASSERT(a_ready_idle, aclk, aresetn, cmd_ready |-> state_reg == ST_IDLE,
        "command taken while busy")
    `MSRPT_ASSERT(a_levels, aclk, aresetn,
        (fast_reg <= 16'd32768) && (slow_reg <= 16'd32768) && (med_reg <= 16'd32768),
        "level above full scale")
endmodule
`default_nettype wire

@@ sim/tb_multi_scale_rms_peak_tracker_top.sv @@
// Self-checking testbench for the multi-scale RMS and peak level meter.
`timescale 1ns / 1ps
module tb_multi_scale_rms_peak_tracker_top;
    import msrpt_pkg::*;

    // Eight result fields, index 0 is crest factor, 7 is the historical peak.
    typedef logic [7:0][15:0] levels_t;

    // One row of the directed table; typed expectations are optional.
    typedef struct {
        mode_t       mode;
        logic [15:0] sample;
        logic        last;
        logic        typed;
        levels_t     want;
    } row_t;

    localparam int SETTLE = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic [1:0] s_mode = '0;
    logic signed [15:0] s_sample = '0;
    logic s_last = 1'b0;
    logic m_ready = 1'b0;
    wire s_ready, m_valid;
    wire [15:0] m_crest_factor, m_dynamic_range, m_loudness, m_peak_out;
    wire [15:0] m_fast_level, m_medium_level, m_slow_level, m_max_peak_out;

    // Settings that the predictor mirrors.
    logic [15:0] c_fast, c_medium, c_slow, c_peak, c_floor;
    logic c_nonres;
    // Predicted block and level state.
    logic [63:0] acc_squares;
    logic [31:0] acc_peak, acc_count;
    logic [31:0] lvl_fast, lvl_medium, lvl_slow, lvl_peak, lvl_hist;

    levels_t pending_levels[$];
    int errors = 0;
    int blocks_seen = 0;
    int items_sent = 0;
    bit quiet_phase = 1'b0;
    string field_names[8] = '{"crest_factor", "dynamic_range", "loudness", "peak_out",
                              "fast_level", "medium_level", "slow_level", "max_peak_out"};

    multi_scale_rms_peak_tracker_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .s_sample(s_sample), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_crest_factor(m_crest_factor), .m_dynamic_range(m_dynamic_range),
        .m_loudness(m_loudness), .m_peak_out(m_peak_out),
        .m_fast_level(m_fast_level), .m_medium_level(m_medium_level),
        .m_slow_level(m_slow_level), .m_max_peak_out(m_max_peak_out)
    );

    // The clock runs with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The run is stopped here if the block hangs.
    initial begin
        #4000000;
        $display("multi_scale_rms_peak_tracker_top test failed");
        $finish;
    end

    // One-pole smoothing, rounded half up.
    function automatic logic [31:0] smooth(logic [31:0] old, logic [31:0] tgt,
                                           logic [15:0] c);
        logic [63:0] v;
        v = old * (64'd65536 - c) + tgt * c + 64'd32768;
        return v[47:16];
    endfunction

    // Floor of the square root, worked out bit by bit from the top.
    function automatic logic [31:0] root_floor(logic [63:0] x);
        logic [31:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            logic [31:0] t;
            t = r | (32'd1 << b);
            if ({32'd0, t} * t <= x) r = t;
        end
        return r;
    endfunction

    // Q8.8 ratio that reads 1.0 when the denominator is zero.
    function automatic logic [15:0] q8_ratio(logic [31:0] num, logic [31:0] den);
        logic [31:0] q;
        if (den == 0) return RATIO_ONE;
        q = (num << 8) / den;
        return (q > 32'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [31:0] slow_decay(logic [31:0] x);
        logic [63:0] v;
        v = x * 64'd65529;
        return v[47:16];
    endfunction

    // Raises the three RMS levels to the floor when the meter keeps its memory.
    function automatic void hold_floor();
        logic [31:0] f;
        if (!c_nonres) return;
        f = (c_floor > 16'd32768) ? 32'd32768 : {16'd0, c_floor};
        if (lvl_fast < f) lvl_fast = f;
        if (lvl_medium < f) lvl_medium = f;
        if (lvl_slow < f) lvl_slow = f;
    endfunction

    // Advances the mirrored meter by one accepted transfer; returns 1 when a block closed.
    function automatic bit meter_step(mode_t mode, logic [15:0] raw, logic last,
                                      output levels_t lv);
        logic [31:0] mag, rms;
        logic [63:0] loud;
        lv = '0;
        case (mode)
            MODE_SAMPLE: begin
                mag = raw[15] ? (32'd65536 - raw) : raw;
                acc_squares += mag * mag;
                if (mag > acc_peak) acc_peak = mag;
                acc_count++;
                if (!(last || acc_count >= BLOCK_MAX)) return 0;
                rms = root_floor(acc_squares / acc_count);
                if (rms > 32768) rms = 32768;
                lvl_fast = smooth(lvl_fast, rms, c_fast);
                lvl_medium = smooth(lvl_medium, rms, c_medium);
                lvl_slow = smooth(lvl_slow, rms, c_slow);
                if (acc_peak > lvl_peak) begin
                    lvl_peak = acc_peak;
                    if (acc_peak > lvl_hist) lvl_hist = acc_peak;
                end else begin
                    lvl_peak = smooth(lvl_peak, acc_peak, c_peak);
                end
                hold_floor();
                acc_squares = 0;
                acc_peak = 0;
                acc_count = 0;
                loud = 64'd13107 * lvl_fast + 64'd32768 * lvl_medium
                     + 64'd19661 * lvl_slow + 64'd32768;
                lv[0] = q8_ratio(lvl_peak, lvl_fast);
                lv[1] = q8_ratio(lvl_hist, lvl_slow);
                lv[2] = loud[31:16];
                lv[3] = lvl_peak[15:0];
                lv[4] = lvl_fast[15:0];
                lv[5] = lvl_medium[15:0];
                lv[6] = lvl_slow[15:0];
                lv[7] = lvl_hist[15:0];
                return 1;
            end
            MODE_DECAY: begin
                lvl_fast = slow_decay(lvl_fast);
                lvl_medium = slow_decay(lvl_medium);
                lvl_slow = slow_decay(lvl_slow);
                lvl_hist = slow_decay(lvl_hist);
                hold_floor();
            end
            MODE_SOFT: begin
                if (!c_nonres) begin
                    lvl_fast = 0; lvl_medium = 0; lvl_slow = 0;
                    lvl_peak = 0; lvl_hist = 0;
                end else begin
                    hold_floor();
                end
            end
            default: ;
        endcase
        return 0;
    endfunction

    // Mostly no gap or a short one, a few long ones, none at all during a quiet phase.
    function automatic int idle_len();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Presents one item at a falling edge and holds it until the transfer.
    task automatic send(mode_t mode, logic [15:0] raw, logic last, output levels_t lv,
                        output bit closed);
        repeat (idle_len()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode = mode;
        s_sample = raw;
        s_last = last;
        do @(posedge aclk); while (!s_ready);
        closed = meter_step(mode, raw, last, lv);
        if (closed) pending_levels.push_back(lv);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Waits until every result is in and the back part has drained.
    task automatic drain();
        while (pending_levels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_FAST: c_fast = val;
            REG_MEDIUM: c_medium = val;
            REG_SLOW: c_slow = val;
            REG_PEAK: c_peak = val;
            REG_NONRES: c_nonres = val[0];
            REG_FLOOR: c_floor = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(logic [15:0] f, logic [15:0] m, logic [15:0] s,
                             logic [15:0] p, logic nr, logic [15:0] fl);
        drain();
        write_reg(REG_FAST, f);
        write_reg(REG_MEDIUM, m);
        write_reg(REG_SLOW, s);
        write_reg(REG_PEAK, p);
        write_reg(REG_NONRES, {15'd0, nr});
        write_reg(REG_FLOOR, fl);
    endtask

    // Samples lean toward the extremes so that saturation is exercised.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly whole blocks of random content, with commands mixed in between.
    task automatic random_traffic(int n_items);
        levels_t lv;
        bit closed;
        int n;
        int len;
        n = 0;
        while (n < n_items) begin
            case ($urandom_range(0, 9))
                0: send(MODE_DECAY, 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)), lv, closed);
                1: send(MODE_SOFT, 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)), lv, closed);
                2: send(MODE_NONE, 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)), lv, closed);
                default: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        send(MODE_SAMPLE, pick_sample(), i == len - 1, lv, closed);
                    n += len - 1;
                end
            endcase
            n++;
        end
    endtask

    // The result side stalls at random, with a quiet stretch in some phases.
    initial begin
        forever begin
            @(negedge aclk);
            if (quiet_phase || $urandom_range(0, 99) < 65) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                repeat (($urandom_range(0, 19) == 0) ? $urandom_range(8, 60)
                                                     : $urandom_range(0, 3))
                    @(negedge aclk);
            end
        end
    end

    // Each transfer on the result side is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            levels_t got;
            got = {m_max_peak_out, m_slow_level, m_medium_level, m_fast_level,
                   m_peak_out, m_loudness, m_dynamic_range, m_crest_factor};
            if (pending_levels.size() == 0) begin
                $display("%0t: result with none predicted, got %h", $time, got);
                errors++;
            end else begin
                levels_t want;
                want = pending_levels.pop_front();
                for (int i = 0; i < 8; i++)
                    if (want[i] !== got[i]) begin
                        $display("%0t: %s expected %0d actual %0d", $time,
                                 field_names[i], want[i], got[i]);
                        errors++;
                    end
            end
            blocks_seen++;
        end
    end

    initial begin
        row_t rows[$];
        row_t r;
        levels_t lv;
        levels_t zero_levels;
        bit closed;
        int wait_cycles;

        c_fast = 65; c_medium = 13; c_slow = 3; c_peak = 7;
        c_nonres = 0; c_floor = 0;
        acc_squares = 0; acc_peak = 0; acc_count = 0;
        lvl_fast = 0; lvl_medium = 0; lvl_slow = 0; lvl_peak = 0; lvl_hist = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows; a silent block right after reset gives ratios of 1.0 and
        // zero levels, which can be typed in directly.
        zero_levels = '0;
        zero_levels[0] = 16'd256;
        zero_levels[1] = 16'd256;
        rows.push_back('{MODE_SAMPLE, 16'h0000, 1'b1, 1'b1, zero_levels});
        rows.push_back('{MODE_NONE,   16'hFFFF, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h8000, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h7FFF, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h0001, 1'b0, 1'b0, '0});
        rows.push_back('{MODE_DECAY,  16'h1234, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'hFFFF, 1'b0, 1'b0, '0});
        rows.push_back('{MODE_SOFT,   16'h0000, 1'b0, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h4000, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h0000, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_DECAY,  16'h0000, 1'b0, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'hC000, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SOFT,   16'hFFFF, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h0000, 1'b1, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h8001, 1'b0, 1'b0, '0});
        rows.push_back('{MODE_SAMPLE, 16'h7FFF, 1'b1, 1'b0, '0});
        foreach (rows[i]) begin
            r = rows[i];
            send(r.mode, r.sample, r.last, lv, closed);
            if (r.typed && (!closed || lv !== r.want)) begin
                $display("%0t: directed row %0d expected %h actual prediction %h",
                         $time, i, r.want, lv);
                errors++;
            end
        end

        // Default settings, random traffic with gaps on both sides.
        random_traffic(80);

        // Fastest tracking with memory held at a floor above full scale.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        random_traffic(50);

        // Frozen levels, keeping memory with a zero floor, and no idling.
        quiet_phase = 1'b1;
        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000);
        random_traffic(50);
        quiet_phase = 1'b0;

        // Memory kept at full scale.
        configure(16'd4000, 16'd900, 16'd60, 16'd300, 1'b1, 16'd32768);
        random_traffic(40);

        // Random settings, one set per phase.
        repeat (3) begin
            configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 40000)));
            random_traffic(60);
        end

        wait_cycles = 0;
        while (pending_levels.size() != 0 && wait_cycles < 100000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE) @(negedge aclk);
        if (pending_levels.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time,
                     pending_levels.size());
            errors++;
        end

        $display("Drove %0d transfers over seven register settings, checked %0d block results.",
                 items_sent, blocks_seen);
        if (errors == 0) begin
            $display("multi_scale_rms_peak_tracker_top test passed");
        end else begin
            $display("multi_scale_rms_peak_tracker_top test failed");
        end
        $finish;
    end
endmodule
